>>> hdl/wlch_pkg.sv
`default_nettype none
package wlch_pkg;

	localparam int MAX_WORD_LENGTH = 30;
	localparam int CHAR_CODES      = 128;
	localparam int COUNT_WIDTH     = 32;

	localparam int LEN_AW  = $clog2(MAX_WORD_LENGTH);
	localparam int LEN_W   = $clog2(MAX_WORD_LENGTH + 1);
	localparam int CHAR_AW = $clog2(CHAR_CODES);

	typedef logic [COUNT_WIDTH-1:0] count_t;

	typedef enum logic [1:0] {
		CMD_TEXT = 2'd0,
		CMD_EOL  = 2'd1,
		CMD_READ = 2'd2
	} cmd_t;

	localparam logic [7:0] CHR_SPACE = 8'd32;
	localparam logic [7:0] CHR_TAB   = 8'd9;
	localparam logic [7:0] CHR_CR    = 8'd13;

endpackage
`default_nettype wire

>>> hdl/wlch_if.sv
`default_nettype none
interface wlch_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] text_byte;
	logic [4:0] length_bin;
	logic [6:0] char_code;

	modport source (output valid, cmd, text_byte, length_bin, char_code, input ready);
	modport sink (input valid, cmd, text_byte, length_bin, char_code, output ready);
endinterface

interface wlch_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] length_count;
	logic [31:0] char_count;

	modport source (output valid, length_count, char_count, input ready);
	modport sink (input valid, length_count, char_count, output ready);
endinterface
`default_nettype wire

>>> hdl/wlch_ram.sv
`default_nettype none
module wlch_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

>>> hdl/word_length_char_histogram.sv
`default_nettype none
// Splits a byte stream into whitespace-separated tokens and keeps two saturating
// histograms in on-chip RAM: token length (bin = length - 1, long tokens land in the
// last bin) and character code over the first bytes of each token. One beat is taken
// every cycle unless stalled; each beat does a single read-modify-write per histogram
// RAM, read in the accept cycle and written back the cycle after, with a one-entry bypass
// covering back-to-back hits on the same bin. A read command returns its beat via the
// stage-one register and an output register. The input stalls only while a read result
// waits unaccepted in that register and a later read sits in stage one. Reset clears
// both histograms at once through per-entry valid flags, so no clearing pass is needed.
module word_length_char_histogram (
	input  wire logic     clk,
	input  wire logic     arst_n,
	wlch_item_if.sink     item,
	wlch_result_if.source result
);
	typedef struct packed {
		logic                           rd;
		logic                           len_wr;
		logic                           len_ok;
		logic                           len_vld;
		logic [wlch_pkg::LEN_AW-1:0]    len_addr;
		logic                           char_wr;
		logic                           char_vld;
		logic [wlch_pkg::CHAR_AW-1:0]   char_addr;
	} op_t;

	typedef struct packed {
		logic                           len_en;
		logic [wlch_pkg::LEN_AW-1:0]    len_addr;
		wlch_pkg::count_t               len_data;
		logic                           char_en;
		logic [wlch_pkg::CHAR_AW-1:0]   char_addr;
		wlch_pkg::count_t               char_data;
	} bypass_t;

	localparam wlch_pkg::count_t COUNT_MAX = '1;

	logic                              accept;
	logic                              advance;
	logic                              is_space;
	op_t                               op_s0;
	op_t                               op_s1;
	logic                              valid_s1;
	logic [wlch_pkg::LEN_W-1:0]        open_len_q;
	logic [wlch_pkg::LEN_W-1:0]        open_len_d;
	logic [wlch_pkg::MAX_WORD_LENGTH-1:0] len_vbits_q;
	logic [wlch_pkg::CHAR_CODES-1:0]   char_vbits_q;
	bypass_t                           byp_q;
	wlch_pkg::count_t                  len_rdata;
	wlch_pkg::count_t                  char_rdata;
	wlch_pkg::count_t                  len_cur;
	wlch_pkg::count_t                  char_cur;
	wlch_pkg::count_t                  len_new;
	wlch_pkg::count_t                  char_new;
	logic                              len_we;
	logic                              char_we;
	logic                              out_valid_q;
	wlch_pkg::count_t                  len_count_q;
	wlch_pkg::count_t                  char_count_q;

	assign advance    = !valid_s1 || !op_s1.rd || !out_valid_q || result.ready;
	assign item.ready = advance;
	assign accept     = item.valid && advance;

	assign is_space = (item.text_byte == wlch_pkg::CHR_SPACE) ||
		((item.text_byte >= wlch_pkg::CHR_TAB) && (item.text_byte <= wlch_pkg::CHR_CR));

	always_comb begin
		op_s0      = '0;
		open_len_d = open_len_q;
		unique case (wlch_pkg::cmd_t'(item.cmd))
			wlch_pkg::CMD_TEXT: begin
				if (is_space) begin
					op_s0.len_wr   = (open_len_q != '0);
					op_s0.len_addr = wlch_pkg::LEN_AW'(open_len_q - 1'b1);
					open_len_d     = '0;
				end else if (open_len_q < wlch_pkg::LEN_W'(wlch_pkg::MAX_WORD_LENGTH)) begin
					op_s0.char_wr   = ({1'b0, item.text_byte} < 9'(wlch_pkg::CHAR_CODES));
					op_s0.char_addr = wlch_pkg::CHAR_AW'(item.text_byte);
					open_len_d      = open_len_q + 1'b1;
				end
			end
			wlch_pkg::CMD_EOL: begin
				op_s0.len_wr   = (open_len_q != '0);
				op_s0.len_addr = wlch_pkg::LEN_AW'(open_len_q - 1'b1);
				open_len_d     = '0;
			end
			wlch_pkg::CMD_READ: begin
				op_s0.rd        = 1'b1;
				op_s0.len_ok    = ({1'b0, item.length_bin} <
					6'(wlch_pkg::MAX_WORD_LENGTH));
				op_s0.len_addr  = wlch_pkg::LEN_AW'(item.length_bin);
				op_s0.char_addr = wlch_pkg::CHAR_AW'(item.char_code);
			end
			default: begin
				op_s0 = '0;
			end
		endcase
		op_s0.len_vld  = len_vbits_q[op_s0.len_addr] &&
			(op_s0.len_ok || op_s0.len_wr);
		op_s0.char_vld = char_vbits_q[op_s0.char_addr];
	end

	wlch_ram #(
		.WIDTH(wlch_pkg::COUNT_WIDTH),
		.DEPTH(wlch_pkg::MAX_WORD_LENGTH)
	) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (op_s1.len_addr),
		.wdata (len_new),
		.re    (accept),
		.raddr (op_s0.len_addr),
		.rdata (len_rdata)
	);

	wlch_ram #(
		.WIDTH(wlch_pkg::COUNT_WIDTH),
		.DEPTH(wlch_pkg::CHAR_CODES)
	) u_char_ram (
		.clk   (clk),
		.we    (char_we),
		.waddr (op_s1.char_addr),
		.wdata (char_new),
		.re    (accept),
		.raddr (op_s0.char_addr),
		.rdata (char_rdata)
	);

	always_comb begin
		if (byp_q.len_en && (byp_q.len_addr == op_s1.len_addr)) begin
			len_cur = byp_q.len_data;
		end else if (op_s1.len_vld) begin
			len_cur = len_rdata;
		end else begin
			len_cur = '0;
		end
		if (byp_q.char_en && (byp_q.char_addr == op_s1.char_addr)) begin
			char_cur = byp_q.char_data;
		end else if (op_s1.char_vld) begin
			char_cur = char_rdata;
		end else begin
			char_cur = '0;
		end
		len_new  = (len_cur == COUNT_MAX) ? len_cur : len_cur + 1'b1;
		char_new = (char_cur == COUNT_MAX) ? char_cur : char_cur + 1'b1;
		len_we   = valid_s1 && op_s1.len_wr;
		char_we  = valid_s1 && op_s1.char_wr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			open_len_q   <= '0;
			len_vbits_q  <= '0;
			char_vbits_q <= '0;
			byp_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (advance) begin
				valid_s1        <= accept;
				byp_q.len_en    <= len_we;
				byp_q.char_en   <= char_we;
				byp_q.len_addr  <= op_s1.len_addr;
				byp_q.len_data  <= len_new;
				byp_q.char_addr <= op_s1.char_addr;
				byp_q.char_data <= char_new;
			end
			if (accept) begin
				open_len_q <= open_len_d;
			end
			if (len_we) begin
				len_vbits_q[op_s1.len_addr] <= 1'b1;
			end
			if (char_we) begin
				char_vbits_q[op_s1.char_addr] <= 1'b1;
			end
			if (advance && valid_s1 && op_s1.rd) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			op_s1 <= op_s0;
		end
		if (advance && valid_s1 && op_s1.rd) begin
			len_count_q  <= op_s1.len_ok ? len_cur : '0;
			char_count_q <= char_cur;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.length_count = len_count_q;
	assign result.char_count   = char_count_q;
endmodule
`default_nettype wire

>>> hdl/wlch_checker.sv
`default_nettype none
module wlch_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        item_valid,
	input wire logic        item_ready,
	input wire logic [1:0]  item_cmd,
	input wire logic [4:0]  item_length_bin,
	input wire logic        result_valid,
	input wire logic        result_ready,
	input wire logic [31:0] result_length_count,
	input wire logic [31:0] result_char_count
);
	// A result beat waiting for the sink keeps its payload.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid &&
		$stable(result_length_count) && $stable(result_char_count))
		else $error("result beat changed while stalled");

	// The input only stalls behind a pending result.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("input stalled with no result pending");

	// A fresh result is traced back to an accepted read command.
	a_result_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |->
		$past(item_valid && item_ready && (item_cmd == wlch_pkg::CMD_READ), 2))
		else $error("result without a read command");

	// Length bins beyond the histogram read as zero.
	a_len_out_of_range: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) &&
		$past(item_cmd == wlch_pkg::CMD_READ &&
		item_length_bin >= 5'(wlch_pkg::MAX_WORD_LENGTH), 2) |->
		result_length_count == '0)
		else $error("out-of-range length bin returned a nonzero count");
endmodule

bind word_length_char_histogram wlch_checker u_wlch_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.item_valid          (item.valid),
	.item_ready          (item.ready),
	.item_cmd            (item.cmd),
	.item_length_bin     (item.length_bin),
	.result_valid        (result.valid),
	.result_ready        (result.ready),
	.result_length_count (result.length_count),
	.result_char_count   (result.char_count)
);
`default_nettype wire

>>> test/histogram_checker.sv
`default_nettype none
module histogram_checker
	import wlch_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	wlch_item_if      item,
	wlch_result_if    result,
	output int        fail_count,
	output int        pending_results,
	output int        reads_checked,
	output int        tokens_closed
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		count_t length_count;
		count_t char_count;
	} bin_pair_t;

	int        open_len;
	count_t    len_bins [MAX_WORD_LENGTH];
	count_t    chr_bins [CHAR_CODES];
	bin_pair_t expected_q [$];
	int        errors;
	int        checked;
	int        closed;

	function automatic count_t bump(count_t v);
		return (v == {COUNT_WIDTH{1'b1}}) ? v : v + 1'b1;
	endfunction

	function automatic logic is_blank(logic [7:0] b);
		return (b == CHR_SPACE) || (b >= CHR_TAB && b <= CHR_CR);
	endfunction

	function automatic void close_token();
		if (open_len != 0) begin
			len_bins[open_len - 1] = bump(len_bins[open_len - 1]);
			open_len = 0;
			closed++;
		end
	endfunction

	function automatic void note_failure(string msg);
		errors++;
		if (errors <= REPORT_LIMIT)
			$display("%t: %s", $realtime, msg);
	endfunction

	function automatic void apply_beat(logic [1:0] c, logic [7:0] b, logic [4:0] lb,
			logic [6:0] cc);
		bin_pair_t e;
		case (c)
			CMD_TEXT: begin
				if (is_blank(b)) begin
					close_token();
				end else if (open_len < MAX_WORD_LENGTH) begin
					if (b < CHAR_CODES)
						chr_bins[b[CHAR_AW-1:0]] = bump(chr_bins[b[CHAR_AW-1:0]]);
					open_len++;
				end
			end
			CMD_EOL: begin
				close_token();
			end
			CMD_READ: begin
				e.length_count = (lb < MAX_WORD_LENGTH) ? len_bins[lb] : '0;
				e.char_count = (cc < CHAR_CODES) ? chr_bins[cc] : '0;
				expected_q.push_back(e);
			end
			default: begin
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bin_pair_t exp_pair;
		if (!arst_n) begin
			open_len = 0;
			foreach (len_bins[i])
				len_bins[i] = '0;
			foreach (chr_bins[i])
				chr_bins[i] = '0;
			expected_q.delete();
			errors = 0;
			checked = 0;
			closed = 0;
		end else begin
			// Results are matched before the same edge's input beat is predicted.
			if (result.valid && result.ready) begin
				if (expected_q.size() == 0) begin
					note_failure($sformatf("unexpected result: length_count %0d char_count %0d",
						result.length_count, result.char_count));
				end else begin
					exp_pair = expected_q.pop_front();
					checked++;
					if (result.length_count !== exp_pair.length_count)
						note_failure($sformatf("length_count mismatch: expected %0d, got %0d",
							exp_pair.length_count, result.length_count));
					if (result.char_count !== exp_pair.char_count)
						note_failure($sformatf("char_count mismatch: expected %0d, got %0d",
							exp_pair.char_count, result.char_count));
				end
			end
			if (item.valid && item.ready)
				apply_beat(item.cmd, item.text_byte, item.length_bin, item.char_code);
		end
		fail_count <= errors;
		pending_results <= expected_q.size();
		reads_checked <= checked;
		tokens_closed <= closed;
	end
endmodule
`default_nettype wire

>>> test/tb_top.sv
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import wlch_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [7:0] CHR_LF = 8'd10;
	localparam logic [7:0] CHR_VT = 8'd11;
	localparam logic [7:0] CHR_FF = 8'd12;
	localparam logic [6:0] CODE_A = 7'h61;
	localparam logic [6:0] CODE_E = 7'h65;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD = 300;
	localparam int IDLE_PART_BEATS = 1150;
	localparam int TOTAL_BEATS = 1950;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   src_idle;
	bit   sink_idle;
	bit   hold_request;
	int   beats_sent;
	int   quiet_cycles;
	int   fail_count;
	int   pending_results;
	int   reads_checked;
	int   tokens_closed;

	wlch_item_if   item_ch ();
	wlch_result_if result_ch ();

	word_length_char_histogram uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	histogram_checker chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.item            (item_ch),
		.result          (result_ch),
		.fail_count      (fail_count),
		.pending_results (pending_results),
		.reads_checked   (reads_checked),
		.tokens_closed   (tokens_closed)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int stall;
		result_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (sink_idle && $urandom_range(0, 6) == 0) begin
				stall = int'($urandom_range(1, 18));
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end else begin
				result_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic send_beat(input logic [1:0] c, input logic [7:0] b, input logic [4:0] lb,
			input logic [6:0] cc);
		int gap;
		if (src_idle && $urandom_range(0, 7) == 0) begin
			gap = int'($urandom_range(1, 18));
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.cmd <= c;
		item_ch.text_byte <= b;
		item_ch.length_bin <= lb;
		item_ch.char_code <= cc;
		do @(posedge clk); while (!item_ch.ready);
		beats_sent++;
	endtask

	function automatic logic [7:0] word_byte();
		logic [7:0] b;
		if ($urandom_range(0, 3) == 0) begin
			b = 8'($urandom_range(0, 255));
			if (b == CHR_SPACE || (b >= CHR_TAB && b <= CHR_CR))
				b = b + 8'd100;
		end else begin
			b = 8'($urandom_range(33, 126));
		end
		return b;
	endfunction

	function automatic logic [7:0] blank_byte();
		logic [7:0] b;
		case ($urandom_range(0, 7))
			0: b = CHR_TAB;
			1: b = CHR_LF;
			2: b = CHR_VT;
			3: b = CHR_FF;
			4: b = CHR_CR;
			default: b = CHR_SPACE;
		endcase
		return b;
	endfunction

	task automatic send_bin_read();
		logic [4:0] lb;
		logic [6:0] cc;
		lb = ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 9)) :
			5'($urandom_range(0, 31));
		cc = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(33, 126)) :
			7'($urandom_range(0, 127));
		send_beat(CMD_READ, 8'($urandom_range(0, 255)), lb, cc);
	endtask

	task automatic send_text(input logic [7:0] b);
		send_beat(CMD_TEXT, b, 5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
	endtask

	task automatic send_blanks(input int n);
		repeat (n) send_text(blank_byte());
	endtask

	task automatic send_word();
		int len;
		len = ($urandom_range(0, 11) == 0) ? int'($urandom_range(25, 40)) :
			int'($urandom_range(1, 9));
		repeat (len) begin
			if ($urandom_range(0, 15) == 0)
				send_bin_read();
			send_text(word_byte());
		end
	endtask

	task automatic send_line();
		int words;
		words = int'($urandom_range(1, 6));
		send_blanks(int'($urandom_range(0, 2)));
		repeat (words) begin
			if ($urandom_range(0, 19) == 0)
				send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
					5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
			send_word();
			if ($urandom_range(0, 1) == 0)
				send_bin_read();
			send_blanks(int'($urandom_range(1, 2)));
		end
		case ($urandom_range(0, 3))
			0, 1: send_beat(CMD_EOL, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
				7'($urandom_range(0, 127)));
			2: send_blanks(1);
			default: begin
			end
		endcase
	endtask

	initial begin
		item_ch.valid <= 1'b0;
		item_ch.cmd <= CMD_TEXT;
		item_ch.text_byte <= 8'h00;
		item_ch.length_bin <= 5'd0;
		item_ch.char_code <= 7'd0;
		src_idle = 1'b1;
		sink_idle = 1'b1;
		hold_request = 1'b0;
		beats_sent = 0;
		wait (arst_n);
		@(posedge clk);

		send_beat(CMD_READ, 8'h00, 5'd0, 7'd0);
		send_beat(CMD_READ, 8'hFF, 5'd31, 7'd127);
		send_beat(CMD_EOL, 8'h00, 5'd0, 7'd0);
		send_text(CHR_SPACE);
		send_text("a");
		send_beat(CMD_READ, 8'h00, 5'd0, CODE_A);
		send_text(CHR_TAB);
		send_text(8'h00);
		send_text(8'h7F);
		send_text(8'h80);
		send_text(8'hFF);
		send_text(CHR_LF);
		send_text("b");
		send_text(CHR_VT);
		send_text("c");
		send_text(CHR_FF);
		send_text("d");
		send_text(CHR_CR);
		send_text("e");
		send_text("e");
		send_beat(CMD_EOL, 8'hFF, 5'd31, 7'd127);
		send_beat(CMD_UNUSED, 8'hFF, 5'd31, 7'd127);
		send_beat(CMD_READ, 8'h00, 5'd0, CODE_E);
		send_beat(CMD_READ, 8'h00, 5'd3, 7'd0);
		send_beat(CMD_READ, 8'h00, 5'd29, 7'd127);
		send_beat(CMD_READ, 8'h00, 5'd30, CODE_A);

		while (beats_sent < IDLE_PART_BEATS)
			send_line();

		// The output is held off while reads keep coming, so the block backs up.
		src_idle = 1'b0;
		hold_request = 1'b1;
		repeat (40) send_bin_read();

		sink_idle = 1'b0;
		while (beats_sent < TOTAL_BEATS)
			send_line();
		item_ch.valid <= 1'b0;

		do @(posedge clk); while (pending_results != 0);
		repeat (8) @(posedge clk);
		$display("Sent %0d beats: %0d tokens closed, %0d bin reads checked.",
			beats_sent, tokens_closed, reads_checked);
		$display("Run included long tokens, every blank code, high bytes and a %0d-cycle hold.",
			LONG_HOLD);
		if (fail_count == 0 && pending_results == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d failures, %0d results still expected", fail_count, pending_results);
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire

>>> sim.f
hdl/wlch_pkg.sv
hdl/wlch_if.sv
hdl/wlch_ram.sv
hdl/word_length_char_histogram.sv
hdl/wlch_checker.sv
test/histogram_checker.sv
test/tb_top.sv
